// File: hw/rtl/llsh_pkg.sv
// llsh_pkg: fixed port widths and heap memory read port count of the least loaded server heap
// no dependencies; used by the top level and the heap memory
package llsh_pkg;

  localparam int ID_OUT_W   = 6;   // server id on the ports
  localparam int DELTA_W    = 32;  // load change on the input
  localparam int LOAD_OUT_W = 32;  // load on the result
  localparam int CNT_IN_W   = 7;   // server count register

  // the heap memory has one port for the item's own entry, the parent or the left child, one for the right child
  localparam int HEAP_RD_PORTS = 2;

endpackage

// File: hw/rtl/llsh_slot_ram.sv
// llsh_slot_ram: id to heap slot map, one write port and one read port
// read data is registered; no dependencies
module llsh_slot_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 6,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_r <= mem_r[raddr];
    end
  end

  assign rdata = rd_r;

endmodule

// File: hw/rtl/llsh_heap_ram.sv
// llsh_heap_ram: heap entry store, one write port and two read ports
// read data is registered; uses llsh_pkg for the port count
module llsh_heap_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 38,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr [llsh_pkg::HEAP_RD_PORTS],
  output logic [WIDTH-1:0] rdata [llsh_pkg::HEAP_RD_PORTS]
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_r  [llsh_pkg::HEAP_RD_PORTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      for (int p = 0; p < llsh_pkg::HEAP_RD_PORTS; p++) begin
        rd_r[p] <= mem_r[raddr[p]];
      end
    end
  end

  assign rdata = rd_r;

endmodule

// File: hw/rtl/least_loaded_server_heap.sv
// least_loaded_server_heap: indexed min-heap of server loads, sequencer and datapath
// uses llsh_pkg, llsh_heap_ram and llsh_slot_ram
//
// channel  | direction | handshake          | payload
// in       | input     | in_valid/in_stall  | in_server_id, in_load_delta
// out      | output    | out_valid/out_stall| out_least_id, out_least_load, out_bad_id
// cfg      | input     | cfg_wr_en          | cfg_wr_data (server count)
//
// a bad id goes straight to the done state; otherwise the item reads its slot, loads
// and updates its entry, walks up, walks down, writes itself back and is done;
// each level is a heap memory read and a compare
// after reset and after every count write a clearing pass rewrites every slot of
// both memories, in_stall is high during it
// the next item is taken while a result waits in the output register
module least_loaded_server_heap #(
  parameter int MAX_SERVERS_P = 64,
  parameter int LOAD_BITS     = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [llsh_pkg::ID_OUT_W-1:0]       in_server_id,
  input  logic signed [llsh_pkg::DELTA_W-1:0] in_load_delta,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [llsh_pkg::ID_OUT_W-1:0]       out_least_id,
  output logic signed [llsh_pkg::LOAD_OUT_W-1:0] out_least_load,
  output logic                                out_bad_id,
  input  logic                                cfg_wr_en,
  input  logic [llsh_pkg::CNT_IN_W-1:0]       cfg_wr_data
);

  localparam int IDW = $clog2(MAX_SERVERS_P);
  localparam int CW  = $clog2(MAX_SERVERS_P + 1);
  localparam int LW  = LOAD_BITS;
  localparam int EW  = IDW + LW;
  localparam int SW  = LW + 33;
  localparam longint LOAD_HI_L = (64'sd1 <<< (LOAD_BITS - 1)) - 64'sd1;
  localparam logic signed [SW-1:0] SAT_HI = SW'(LOAD_HI_L);
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
  localparam logic [CW-1:0] CNT_RESET = (MAX_SERVERS_P > 64) ? CW'(64) : CW'(MAX_SERVERS_P);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MAP   = 4'd1;
  localparam logic [3:0] ST_LOAD  = 4'd2;
  localparam logic [3:0] ST_UP    = 4'd3;
  localparam logic [3:0] ST_UPCMP = 4'd4;
  localparam logic [3:0] ST_DNRD  = 4'd5;
  localparam logic [3:0] ST_DNCMP = 4'd6;
  localparam logic [3:0] ST_FIN   = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  function automatic logic ent_less(input logic [IDW-1:0] a_id,
                                    input logic signed [LW-1:0] a_ld,
                                    input logic [IDW-1:0] b_id,
                                    input logic signed [LW-1:0] b_ld);
    return (a_ld < b_ld) || ((a_ld == b_ld) && (a_id < b_id));
  endfunction

  // control and item registers
  logic [3:0]                state_r, state_nxt;
  logic [IDW-1:0]            k_r, k_nxt;
  logic [IDW-1:0]            id_r, id_nxt;
  logic signed [LW-1:0]      eld_r, eld_nxt;
  logic signed [llsh_pkg::DELTA_W-1:0] delta_r, delta_nxt;
  logic                      bad_r, bad_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic                      clr_r, clr_nxt;
  logic [IDW-1:0]            clr_idx_r, clr_idx_nxt;
  logic [IDW-1:0]            top_id_r, top_id_nxt;
  logic signed [LW-1:0]      top_ld_r, top_ld_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [llsh_pkg::ID_OUT_W-1:0]   out_id_r, out_id_nxt;
  logic [llsh_pkg::LOAD_OUT_W-1:0] out_ld_r, out_ld_nxt;
  logic                      out_bad_r, out_bad_nxt;

  // memory ports
  logic            heap_we, heap_re;
  logic [IDW-1:0]  heap_waddr;
  logic [EW-1:0]   heap_wdata;
  logic [IDW-1:0]  heap_raddr [llsh_pkg::HEAP_RD_PORTS];
  logic [EW-1:0]   heap_rdata [llsh_pkg::HEAP_RD_PORTS];
  logic            slot_we, slot_re;
  logic [IDW-1:0]  slot_waddr, slot_wdata, slot_raddr, slot_rdata;

  // datapath
  logic [IDW+5:0]       in_id_ext;
  logic [IDW-1:0]       in_id;
  logic                 in_bad;
  logic                 in_fire, out_fire;
  logic [IDW-1:0]       par;
  logic [IDW+1:0]       l_ext, r_ext;
  logic                 l_ok, r_ok;
  logic [IDW-1:0]       a_id, b_id;
  logic signed [LW-1:0] a_ld, b_ld;
  logic signed [SW-1:0] sum, sum_sat;
  logic                 l_lt_e, r_lt_e, r_lt_l, pick_r, pick_l;
  logic [CW-1:0]        cfg_cnt;
  logic [llsh_pkg::CNT_IN_W-1:0] cfg_nz;
  logic [IDW+5:0]       top_id_ext;
  logic signed [LW+31:0] top_ld_ext;

  llsh_heap_ram #(
    .DEPTH (MAX_SERVERS_P),
    .WIDTH (EW)
  ) u_heap (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .re    (heap_re),
    .raddr (heap_raddr),
    .rdata (heap_rdata)
  );

  llsh_slot_ram #(
    .DEPTH (MAX_SERVERS_P),
    .WIDTH (IDW)
  ) u_slot (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE) || clr_r;
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;
  assign in_id_ext = (IDW+6)'(in_server_id);
  assign in_id     = in_id_ext[IDW-1:0];
  assign in_bad    = 32'(in_server_id) >= 32'(count_r);

  assign par   = (k_r - 1'b1) >> 1;
  assign l_ext = {1'b0, k_r, 1'b1};
  assign r_ext = l_ext + 1'b1;
  assign l_ok  = 32'(l_ext) < 32'(count_r);
  assign r_ok  = 32'(r_ext) < 32'(count_r);

  assign a_id = heap_rdata[0][EW-1:LW];
  assign a_ld = $signed(heap_rdata[0][LW-1:0]);
  assign b_id = heap_rdata[1][EW-1:LW];
  assign b_ld = $signed(heap_rdata[1][LW-1:0]);

  // saturating add of the change to the loaded entry
  assign sum     = SW'(a_ld) + SW'(delta_r);
  assign sum_sat = (sum > SAT_HI) ? SAT_HI : ((sum < SAT_LO) ? SAT_LO : sum);

  // left child in port 0, right child in port 1
  assign l_lt_e = ent_less(a_id, a_ld, id_r, eld_r);
  assign r_lt_e = ent_less(b_id, b_ld, id_r, eld_r);
  assign r_lt_l = ent_less(b_id, b_ld, a_id, a_ld);
  assign pick_r = r_ok && (l_lt_e ? r_lt_l : r_lt_e);
  assign pick_l = l_lt_e && !pick_r;

  assign cfg_nz  = (cfg_wr_data == '0) ? llsh_pkg::CNT_IN_W'(1) : cfg_wr_data;
  assign cfg_cnt = (32'(cfg_nz) > 32'(MAX_SERVERS_P)) ? CW'(MAX_SERVERS_P) : CW'(cfg_nz);

  assign top_id_ext = (IDW+6)'(top_id_r);
  assign top_ld_ext = (LW+32)'(top_ld_r);

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    id_nxt        = id_r;
    eld_nxt       = eld_r;
    delta_nxt     = delta_r;
    bad_nxt       = bad_r;
    count_nxt     = count_r;
    clr_nxt       = clr_r;
    clr_idx_nxt   = clr_idx_r;
    top_id_nxt    = top_id_r;
    top_ld_nxt    = top_ld_r;
    out_valid_nxt = out_fire ? 1'b0 : out_valid_r;
    out_id_nxt    = out_id_r;
    out_ld_nxt    = out_ld_r;
    out_bad_nxt   = out_bad_r;
    heap_we       = 1'b0;
    heap_re       = 1'b0;
    heap_waddr    = k_r;
    heap_wdata    = {id_r, eld_r};
    heap_raddr[0] = l_ext[IDW-1:0];
    heap_raddr[1] = r_ext[IDW-1:0];
    slot_we       = 1'b0;
    slot_re       = 1'b0;
    slot_waddr    = id_r;
    slot_wdata    = k_r;
    slot_raddr    = in_id;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          id_nxt    = in_id;
          delta_nxt = in_load_delta;
          bad_nxt   = in_bad;
          if (in_bad) begin
            state_nxt = ST_DONE;
          end else begin
            slot_re   = 1'b1;
            state_nxt = ST_MAP;
          end
        end
      end
      ST_MAP: begin
        heap_re       = 1'b1;
        heap_raddr[0] = slot_rdata;
        k_nxt         = slot_rdata;
        state_nxt     = ST_LOAD;
      end
      ST_LOAD: begin
        eld_nxt   = LW'(sum_sat);
        state_nxt = ST_UP;
      end
      ST_UP: begin
        if (k_r == '0) begin
          state_nxt = ST_DNRD;
        end else begin
          heap_re       = 1'b1;
          heap_raddr[0] = par;
          state_nxt     = ST_UPCMP;
        end
      end
      ST_UPCMP: begin
        // the moving entry stays in registers, the parent drops into the hole
        if (ent_less(id_r, eld_r, a_id, a_ld)) begin
          heap_we    = 1'b1;
          heap_wdata = heap_rdata[0];
          slot_we    = 1'b1;
          slot_waddr = a_id;
          k_nxt      = par;
          state_nxt  = ST_UP;
        end else begin
          state_nxt = ST_DNRD;
        end
      end
      ST_DNRD: begin
        if (l_ok) begin
          heap_re   = 1'b1;
          state_nxt = ST_DNCMP;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_DNCMP: begin
        if (pick_r) begin
          heap_we    = 1'b1;
          heap_wdata = heap_rdata[1];
          slot_we    = 1'b1;
          slot_waddr = b_id;
          k_nxt      = r_ext[IDW-1:0];
          state_nxt  = ST_DNRD;
        end else if (pick_l) begin
          heap_we    = 1'b1;
          heap_wdata = heap_rdata[0];
          slot_we    = 1'b1;
          slot_waddr = a_id;
          k_nxt      = l_ext[IDW-1:0];
          state_nxt  = ST_DNRD;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        heap_we   = 1'b1;
        slot_we   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = top_id_ext[llsh_pkg::ID_OUT_W-1:0];
          out_ld_nxt    = top_ld_ext[llsh_pkg::LOAD_OUT_W-1:0];
          out_bad_nxt   = bad_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // clearing pass, only ever runs while idle
    if (clr_r) begin
      heap_we     = 1'b1;
      heap_waddr  = clr_idx_r;
      heap_wdata  = {clr_idx_r, LW'(0)};
      slot_we     = 1'b1;
      slot_waddr  = clr_idx_r;
      slot_wdata  = clr_idx_r;
      clr_idx_nxt = clr_idx_r + 1'b1;
      if (32'(clr_idx_r) == MAX_SERVERS_P - 1) begin
        clr_nxt = 1'b0;
      end
    end

    // slot zero mirror for the result
    if (heap_we && (heap_waddr == '0)) begin
      top_id_nxt = heap_wdata[EW-1:LW];
      top_ld_nxt = $signed(heap_wdata[LW-1:0]);
    end

    if (cfg_wr_en) begin
      count_nxt   = cfg_cnt;
      clr_nxt     = 1'b1;
      clr_idx_nxt = '0;
      state_nxt   = ST_IDLE;
      top_id_nxt  = '0;
      top_ld_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= CNT_RESET;
      clr_r       <= 1'b1;
      clr_idx_r   <= '0;
      top_id_r    <= '0;
      top_ld_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      clr_r       <= clr_nxt;
      clr_idx_r   <= clr_idx_nxt;
      top_id_r    <= top_id_nxt;
      top_ld_r    <= top_ld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    id_r      <= id_nxt;
    eld_r     <= eld_nxt;
    delta_r   <= delta_nxt;
    bad_r     <= bad_nxt;
    out_id_r  <= out_id_nxt;
    out_ld_r  <= out_ld_nxt;
    out_bad_r <= out_bad_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_least_id   = out_id_r;
  assign out_least_load = $signed(out_ld_r);
  assign out_bad_id     = out_bad_r;

  // clearing never overlaps a heap walk
  a_clr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> state_r == ST_IDLE)
    else $error("clearing pass while an item is in flight");

  // a result only appears from the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result loaded outside the done state");

  // an accepted item leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !cfg_wr_en |=> state_r != ST_IDLE)
    else $error("accepted item did not start");

  // the walk never leaves the servers in use
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UP || state_r == ST_UPCMP || state_r == ST_DNRD ||
     state_r == ST_DNCMP || state_r == ST_FIN) |-> 32'(k_r) < 32'(count_r))
    else $error("heap slot beyond server count");

endmodule

// File: test/tb_top.sv
// tb_top: self-checking bench for least_loaded_server_heap, random and directed load changes
// depends on llsh_pkg and the block's rtl; keeps its own copy of the indexed heap to
// predict the least loaded server after each item
`timescale 1ns / 100ps

module tb_top;

  localparam int SERVERS        = 64;
  localparam int LOAD_BITS      = 32;
  localparam longint LOAD_HI    = (longint'(1) << (LOAD_BITS - 1)) - 1;
  localparam longint LOAD_LO    = -LOAD_HI - 1;
  localparam int MAX_WAIT       = 8;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PER_SET = 150;
  localparam int REPORT_LIMIT   = 10;

  typedef struct {
    logic [llsh_pkg::ID_OUT_W-1:0] id;
    longint                        load;
  } heap_slot_t;

  typedef struct {
    logic [llsh_pkg::ID_OUT_W-1:0]   id;
    logic [llsh_pkg::LOAD_OUT_W-1:0] load;
    logic                            bad;
  } least_t;

  // own copy of the heap and id-to-slot map, plus the least servers still owed
  class least_loaded_tracker;
    heap_slot_t heap[SERVERS];
    int         slot_of[SERVERS];
    int         count;
    least_t     owed[$];
    int         errors;

    function void restart(int written);
      count = (written < 1) ? 1 : (written > SERVERS) ? SERVERS : written;
      for (int k = 0; k < SERVERS; k++) begin
        heap[k].id   = llsh_pkg::ID_OUT_W'(k);
        heap[k].load = 0;
        slot_of[k]   = k;
      end
    endfunction

    function bit precedes(heap_slot_t a, heap_slot_t b);
      if (a.load != b.load) return a.load < b.load;
      return a.id < b.id;
    endfunction

    function void exchange(int a, int b);
      heap_slot_t t;
      t = heap[a];
      heap[a] = heap[b];
      heap[b] = t;
      slot_of[heap[a].id] = a;
      slot_of[heap[b].id] = b;
    endfunction

    function void apply_change(logic [llsh_pkg::ID_OUT_W-1:0] id,
                               logic signed [llsh_pkg::DELTA_W-1:0] delta);
      int     s;
      int     p;
      int     l;
      int     r;
      int     best;
      longint sum;
      least_t res;
      res.bad = 1'b1;
      if (id < count) begin
        s = slot_of[id];
        sum = heap[s].load + longint'(delta);
        if (sum > LOAD_HI) sum = LOAD_HI;
        if (sum < LOAD_LO) sum = LOAD_LO;
        heap[s].load = sum;
        while (s > 0) begin
          p = (s - 1) / 2;
          if (!precedes(heap[s], heap[p])) break;
          exchange(s, p);
          s = p;
        end
        while (1) begin
          l = 2 * s + 1;
          r = l + 1;
          best = s;
          if (l < count && precedes(heap[l], heap[best])) best = l;
          if (r < count && precedes(heap[r], heap[best])) best = r;
          if (best == s) break;
          exchange(s, best);
          s = best;
        end
        res.bad = 1'b0;
      end
      res.id   = heap[0].id;
      res.load = llsh_pkg::LOAD_OUT_W'(heap[0].load);
      owed.push_back(res);
    endfunction

    function void check_least(logic [llsh_pkg::ID_OUT_W-1:0] id,
                              logic [llsh_pkg::LOAD_OUT_W-1:0] load, logic bad);
      least_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected result: id %0d load %0d bad %0b", id, $signed(load), bad);
        return;
      end
      want = owed.pop_front();
      if (id !== want.id || load !== want.load || bad !== want.bad) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("mismatch: id %0d/%0d load %0d/%0d bad %0b/%0b (expected/actual)",
                   want.id, id, $signed(want.load), $signed(load), want.bad, bad);
      end
    endfunction
  endclass

  logic                                   clk            = 1'b0;
  logic                                   rst_n          = 1'b0;
  logic                                   in_valid       = 1'b0;
  logic                                   in_stall;
  logic [llsh_pkg::ID_OUT_W-1:0]          in_server_id   = '0;
  logic signed [llsh_pkg::DELTA_W-1:0]    in_load_delta  = '0;
  logic                                   out_valid;
  logic                                   out_stall      = 1'b0;
  logic [llsh_pkg::ID_OUT_W-1:0]          out_least_id;
  logic signed [llsh_pkg::LOAD_OUT_W-1:0] out_least_load;
  logic                                   out_bad_id;
  logic                                   cfg_wr_en      = 1'b0;
  logic [llsh_pkg::CNT_IN_W-1:0]          cfg_wr_data    = '0;

  least_loaded_tracker tracker;
  bit no_idle = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always #6 clk = ~clk;

  least_loaded_server_heap DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_server_id  (in_server_id),
    .in_load_delta (in_load_delta),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_least_id  (out_least_id),
    .out_least_load(out_least_load),
    .out_bad_id    (out_bad_id),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  // result side: check each item taken, then hold off for a random wait, none while no_idle is set
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else if (out_valid && !out_stall) begin
      tracker.check_least(out_least_id, out_least_load, out_bad_id);
      hold_left = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      out_stall <= (hold_left != 0);
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= (hold_left != 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL least_loaded_server_heap");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [llsh_pkg::ID_OUT_W-1:0] id,
                           input logic signed [llsh_pkg::DELTA_W-1:0] delta);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_server_id  <= id;
    in_load_delta <= delta;
    do @(posedge clk); while (in_stall);
    tracker.apply_change(id, delta);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.owed.size() != 0);
  endtask

  task automatic write_count(input int value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= llsh_pkg::CNT_IN_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.restart(value & 7'h7f);
  endtask

  task automatic random_items(input int n);
    logic [llsh_pkg::ID_OUT_W-1:0]       id;
    logic signed [llsh_pkg::DELTA_W-1:0] delta;
    int                                  pick;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 29) == 0) no_idle = !no_idle;
      // let the heap go quiet once per set before carrying on
      if (i == n / 2) drain();
      if ($urandom_range(0, 9) == 0)
        id = llsh_pkg::ID_OUT_W'($urandom_range(0, SERVERS - 1));
      else
        id = llsh_pkg::ID_OUT_W'($urandom_range(0, tracker.count - 1));
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2: delta = $urandom_range(0, 16) - 8;   // many ties
        3:       delta = '0;
        4:       delta = $urandom_range(0, 2000) - 1000;
        5: begin
          case ($urandom_range(0, 3))
            0:       delta = 32'h7fffffff;
            1:       delta = 32'h80000000;
            2:       delta = 32'h7fffffff - $urandom_range(0, 3);
            default: delta = 32'h80000000 + $urandom_range(0, 3);
          endcase
        end
        default: delta = $urandom;
      endcase
      send_item(id, delta);
    end
  endtask

  initial begin
    int set_counts[];
    set_counts = '{3, 0, 1, 2, 127, 17, 64, 100, 5, 40, 64};
    tracker = new();
    tracker.restart(SERVERS);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // full count: query, saturation both ways, ties broken by lower id
    send_item(0, 0);
    send_item(SERVERS - 1, 32'h7fffffff);
    send_item(SERVERS - 1, 32'h7fffffff);
    send_item(0, 32'h80000000);
    send_item(0, 32'h80000000);
    send_item(0, 32'h7fffffff);
    send_item(5, -1);
    send_item(5, 0);
    send_item(42, 32'h80000000);
    send_item(42, 32'h7fffffff);
    send_item(SERVERS - 1, 32'h80000000);

    // small count: ids at and past the count are flagged
    write_count(3);
    send_item(2, 1);
    send_item(3, 1);
    send_item(SERVERS - 1, -1);
    send_item(0, 0);
    send_item(1, -2);

    foreach (set_counts[s]) begin
      if (s > 0) write_count(set_counts[s]);
      random_items(RANDOM_PER_SET);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.owed.size() == 0) begin
      $display("PASS least_loaded_server_heap");
    end else begin
      $display("FAIL least_loaded_server_heap");
    end
    $finish;
  end

endmodule
